/* hdl/ait_pkg.sv */
package ait_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int WORD_W = 64;
	localparam int DEV_W = 16;
	localparam int FUNC_W = 2;
	localparam int ST_W = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [WORD_W-1:0] FIRST_IDENTITY_RST = WORD_W'(1);

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEVICE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IDENTITY = 8'd1;

	typedef enum logic [ST_W-1:0] {
		ST_OK = 3'd0,
		ST_INVALID = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_DOUBLE_FREE = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] alloc_size;
		logic [WORD_W-1:0] alloc_align;
		logic [WORD_W-1:0] alloc_base;
		logic [WORD_W-1:0] identity;
		logic [DEV_W-1:0] view_device;
		logic [WORD_W-1:0] view_address;
		logic [WORD_W-1:0] view_size;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [WORD_W-1:0] rec_identity;
		logic [WORD_W-1:0] rec_base;
		logic [WORD_W-1:0] rec_size;
		logic [WORD_W-1:0] rec_align;
		logic [CNT_W-1:0] live_count;
		logic [WORD_W-1:0] live_total;
		logic [WORD_W-1:0] peak_total;
		logic [WORD_W-1:0] next_issue;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] idx;
		logic [WORD_W-1:0] data;
	} cfg_wr_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic calc;
		logic check;
		logic commit;
	} dp_cmd_t;

endpackage

/* hdl/ait_if.sv */
interface ait_req_if import ait_pkg::*; ();
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [WORD_W-1:0] alloc_size;
	logic [WORD_W-1:0] alloc_align;
	logic [WORD_W-1:0] alloc_base;
	logic [WORD_W-1:0] identity;
	logic [DEV_W-1:0] view_device;
	logic [WORD_W-1:0] view_address;
	logic [WORD_W-1:0] view_size;

	modport source (output valid, func, alloc_size, alloc_align, alloc_base, identity,
		view_device, view_address, view_size, input ready);
	modport sink (input valid, func, alloc_size, alloc_align, alloc_base, identity,
		view_device, view_address, view_size, output ready);
endinterface

interface ait_rsp_if import ait_pkg::*; ();
	logic valid;
	logic ready;
	logic [ST_W-1:0] status;
	logic [WORD_W-1:0] rec_identity;
	logic [WORD_W-1:0] rec_base;
	logic [WORD_W-1:0] rec_size;
	logic [WORD_W-1:0] rec_align;
	logic [CNT_W-1:0] live_count;
	logic [WORD_W-1:0] live_total;
	logic [WORD_W-1:0] peak_total;
	logic [WORD_W-1:0] next_issue;

	modport source (output valid, status, rec_identity, rec_base, rec_size, rec_align,
		live_count, live_total, peak_total, next_issue, input ready);
	modport sink (input valid, status, rec_identity, rec_base, rec_size, rec_align,
		live_count, live_total, peak_total, next_issue, output ready);
endinterface

interface ait_cfg_if import ait_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/ait_ram.sv */
module ait_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read held between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/ait_ctrl.sv */
module ait_ctrl import ait_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic rsp_ready,
	output logic req_ready,
	output logic rsp_valid,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_CALC,
		S_CHECK,
		S_DECIDE
	} state_t;

	state_t state_q;
	logic req_ready_q;
	logic rsp_valid_q;
	logic accept;
	logic retire;

	assign req_ready = req_ready_q;
	assign rsp_valid = rsp_valid_q;
	assign accept = req_valid && req_ready_q;
	// the result register is free, or empties in this cycle
	assign retire = (state_q == S_DECIDE) && (!rsp_valid_q || rsp_ready);

	// datapath commands decoded from the state and the handshakes
	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.lookup = (state_q == S_LOOKUP);
		cmd.calc = (state_q == S_CALC);
		cmd.check = (state_q == S_CHECK);
		cmd.commit = retire;
	end

	// sequencer and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result refills the register as the old one leaves
			if (retire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOKUP;
						req_ready_q <= 1'b0;
					end
				end
				S_LOOKUP: state_q <= S_CALC;
				S_CALC: state_q <= S_CHECK;
				S_CHECK: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (retire) begin
						state_q <= S_IDLE;
						req_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					req_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* hdl/ait_dp.sv */
module ait_dp import ait_pkg::*; (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input req_t req,
	input cfg_wr_t cfg_wr,
	output rsp_t rsp
);

	// table and running totals
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [WORD_W-1:0] ident_q [TABLE_DEPTH];
	logic [DEV_W-1:0] own_device_q;
	logic [WORD_W-1:0] issue_q;
	logic [WORD_W-1:0] live_q;
	logic [WORD_W-1:0] peak_q;
	logic [CNT_W-1:0] count_q;

	req_t req_q;
	rsp_t rsp_q;

	// lookup stage
	logic [WORD_W-1:0] key;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic hit;
	logic free_any;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] slot_idx;
	logic size_zero;
	logic align_bad;
	status_t pre_st;
	status_t pre_st_s1;
	logic [IDX_W-1:0] idx_s1;

	// record read from the slot memory
	logic [3*WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] base_rd;
	logic [WORD_W-1:0] size_rd;
	logic [WORD_W-1:0] align_rd;

	// range and total arithmetic
	logic [WORD_W-1:0] off_s2;
	logic lt_s2;
	logic eq_s2;
	logic [WORD_W-1:0] sum_s2;
	logic [WORD_W-1:0] dif_s2;
	logic [WORD_W-1:0] rem_s3;
	logic ogt_s3;
	logic pgt_s3;

	// decision
	status_t st;
	logic ok;
	logic do_alloc;
	logic do_free;
	logic ram_we;
	rsp_t rsp_nx;

	assign rsp = rsp_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// parallel identity compare and lowest free slot
	always_comb begin
		key = (req_q.func == FUNC_ALLOC) ? issue_q : req_q.identity;
		hit_idx = '0;
		free_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (ident_q[i] == key);
		end
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		hit = |hit_vec;
		free_any = ~&valid_q;
		slot_idx = (req_q.func == FUNC_ALLOC) ? free_idx : hit_idx;
	end

	// checks that need no stored record
	always_comb begin
		size_zero = (req_q.alloc_size == '0);
		align_bad = (req_q.alloc_align != '0) &&
			((req_q.alloc_align & (req_q.alloc_align - WORD_W'(1))) != '0);
		case (req_q.func)
			FUNC_ALLOC: begin
				if (size_zero || align_bad) begin
					pre_st = ST_INVALID;
				end else if (issue_q == ALL_ONES) begin
					pre_st = ST_EXHAUSTED;
				end else if (hit) begin
					pre_st = ST_INVALID;
				end else if (!free_any) begin
					pre_st = ST_FULL;
				end else begin
					pre_st = ST_OK;
				end
			end
			FUNC_FREE, FUNC_RESOLVE: begin
				if (!hit) begin
					pre_st = (req_q.identity != '0 && req_q.identity < issue_q) ?
						ST_DOUBLE_FREE : ST_INVALID;
				end else if (req_q.view_device != own_device_q) begin
					pre_st = ST_INVALID;
				end else begin
					pre_st = ST_OK;
				end
			end
			default: pre_st = ST_INVALID;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			pre_st_s1 <= pre_st;
			idx_s1 <= slot_idx;
		end
	end

	// base, size and alignment of each slot
	assign ram_we = cmd.commit && do_alloc;

	ait_ram #(
		.WIDTH(3 * WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_s1),
		.wdata({req_q.alloc_align, req_q.alloc_size, req_q.alloc_base}),
		.re(cmd.lookup),
		.raddr(slot_idx),
		.rdata(rd_data)
	);

	assign base_rd = rd_data[WORD_W-1:0];
	assign size_rd = rd_data[2*WORD_W-1:WORD_W];
	assign align_rd = rd_data[3*WORD_W-1:2*WORD_W];

	// view offset and new totals
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			off_s2 <= req_q.view_address - base_rd;
			lt_s2 <= req_q.view_address < base_rd;
			eq_s2 <= (req_q.view_address == base_rd) && (req_q.view_size == size_rd);
			sum_s2 <= live_q + req_q.alloc_size;
			dif_s2 <= live_q - size_rd;
		end
	end

	// room left behind the offset, and the high-water compare
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			rem_s3 <= size_rd - off_s2;
			ogt_s3 <= off_s2 > size_rd;
			pgt_s3 <= sum_s2 > peak_q;
		end
	end

	// final status and result
	always_comb begin
		st = pre_st_s1;
		if (pre_st_s1 == ST_OK) begin
			case (req_q.func)
				FUNC_FREE: begin
					if (!eq_s2) begin
						st = ST_INVALID;
					end
				end
				FUNC_RESOLVE: begin
					if (req_q.view_size != '0 &&
						(lt_s2 || ogt_s3 || req_q.view_size > rem_s3)) begin
						st = ST_INVALID;
					end
				end
				default: st = pre_st_s1;
			endcase
		end
		ok = (st == ST_OK);
		do_alloc = ok && (req_q.func == FUNC_ALLOC);
		do_free = ok && (req_q.func == FUNC_FREE);

		rsp_nx = '0;
		rsp_nx.status = st;
		if (do_alloc) begin
			rsp_nx.rec_identity = issue_q;
			rsp_nx.rec_base = req_q.alloc_base;
			rsp_nx.rec_size = req_q.alloc_size;
			rsp_nx.rec_align = req_q.alloc_align;
		end else if (ok) begin
			rsp_nx.rec_identity = req_q.identity;
			rsp_nx.rec_base = base_rd;
			rsp_nx.rec_size = size_rd;
			rsp_nx.rec_align = align_rd;
		end
		rsp_nx.next_issue = do_alloc ? issue_q + WORD_W'(1) : issue_q;
		rsp_nx.live_total = do_alloc ? sum_s2 : (do_free ? dif_s2 : live_q);
		rsp_nx.peak_total = (do_alloc && pgt_s3) ? sum_s2 : peak_q;
		if (do_alloc) begin
			rsp_nx.live_count = count_q + CNT_W'(1);
		end else if (do_free) begin
			rsp_nx.live_count = count_q - CNT_W'(1);
		end else begin
			rsp_nx.live_count = count_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_nx;
		end
	end

	// identities of the slots
	always_ff @(posedge clk) begin
		if (cmd.commit && do_alloc) begin
			ident_q[idx_s1] <= issue_q;
		end
	end

	// table state, totals and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			own_device_q <= '0;
			issue_q <= FIRST_IDENTITY_RST;
			live_q <= '0;
			peak_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.commit) begin
				if (do_alloc) begin
					valid_q[idx_s1] <= 1'b1;
				end else if (do_free) begin
					valid_q[idx_s1] <= 1'b0;
				end
				issue_q <= rsp_nx.next_issue;
				live_q <= rsp_nx.live_total;
				peak_q <= rsp_nx.peak_total;
				count_q <= rsp_nx.live_count;
			end
			if (cfg_wr.we) begin
				if (cfg_wr.idx == CFG_OWN_DEVICE) begin
					own_device_q <= cfg_wr.data[DEV_W-1:0];
				end else if (cfg_wr.idx == CFG_FIRST_IDENTITY) begin
					issue_q <= cfg_wr.data;
				end
			end
		end
	end

endmodule

/* hdl/allocation_identity_table_top.sv */
// allocation identity table
//
// req carries allocate, free and resolve requests; each accepted item gives
// exactly one item on rsp with the status, the matched or issued record and
// the live count, byte total, high-water mark and next identity after it.
// cfg writes own_device (index 0) and first_identity (index 1, which also
// loads the issue counter); writes are taken in any cycle and belong to idle
// periods. writes to other indexes are ignored.
//
// one item is worked on at a time, in steps from acceptance to the result
// register (lookup with the identity compare over all slots and the slot
// memory read, offset and totals, range checks, decision). req is ready
// again in the cycle after the result is loaded, so a new item is taken
// only once the last one has reached the result register.
//
// reset clears all slots, the totals and the live count, sets the issue
// counter to one and own_device to zero; no clearing pass is needed.
// when rsp stalls, the finished item waits in the result register while the
// next item is accepted and worked on; that one then waits in its final
// step until the register empties.
module allocation_identity_table_top import ait_pkg::*; (
	input logic clk,
	input logic arst_n,
	ait_req_if.sink req,
	ait_rsp_if.source rsp,
	ait_cfg_if.sink cfg
);

	dp_cmd_t cmd;
	req_t req_pl;
	rsp_t rsp_pl;
	cfg_wr_t cfg_wr;

	// request payload into one word
	always_comb begin
		req_pl.func = req.func;
		req_pl.alloc_size = req.alloc_size;
		req_pl.alloc_align = req.alloc_align;
		req_pl.alloc_base = req.alloc_base;
		req_pl.identity = req.identity;
		req_pl.view_device = req.view_device;
		req_pl.view_address = req.view_address;
		req_pl.view_size = req.view_size;
	end

	// configuration writes are always taken
	assign cfg.ready = 1'b1;
	always_comb begin
		cfg_wr.we = cfg.valid;
		cfg_wr.idx = cfg.index;
		cfg_wr.data = cfg.data;
	end

	ait_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.rsp_ready(rsp.ready),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.cmd(cmd)
	);

	ait_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req_pl),
		.cfg_wr(cfg_wr),
		.rsp(rsp_pl)
	);

	// result payload out to the channel
	assign rsp.status = rsp_pl.status;
	assign rsp.rec_identity = rsp_pl.rec_identity;
	assign rsp.rec_base = rsp_pl.rec_base;
	assign rsp.rec_size = rsp_pl.rec_size;
	assign rsp.rec_align = rsp_pl.rec_align;
	assign rsp.live_count = rsp_pl.live_count;
	assign rsp.live_total = rsp_pl.live_total;
	assign rsp.peak_total = rsp_pl.peak_total;
	assign rsp.next_issue = rsp_pl.next_issue;

endmodule

/* hdl/ait_checker.sv */
module ait_checker import ait_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [ST_W-1:0] rsp_status,
	input logic [WORD_W-1:0] rec_identity,
	input logic [WORD_W-1:0] rec_base,
	input logic [WORD_W-1:0] rec_size,
	input logic [WORD_W-1:0] rec_align,
	input logic [CNT_W-1:0] live_count
);

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rec_identity))
		else $error("result item changed while stalled");

	// one item in flight: no second acceptance straight after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another item is in work");

	// a failed request carries an empty record
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
			rec_identity == '0 && rec_base == '0 && rec_size == '0 && rec_align == '0)
		else $error("record fields set on a failed request");

	// every live record has a nonzero size
	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_OK |-> rec_size != '0)
		else $error("successful request with an empty record");

	// the live count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> live_count <= CNT_W'(TABLE_DEPTH))
		else $error("live count beyond table depth");

endmodule

bind allocation_identity_table_top ait_checker u_ait_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rec_identity(rsp.rec_identity),
	.rec_base(rsp.rec_base),
	.rec_size(rsp.rec_size),
	.rec_align(rsp.rec_align),
	.live_count(rsp.live_count)
);
